[hw/rtl/cave_pkg.sv]
// Shared types, constants and the cell rule for the cave automaton row step.
package cave_pkg;

    localparam int LINE_W  = 64;
    localparam int THR_W   = 4;
    localparam int CNT_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVOID_BIG       = 2'd2;

    localparam logic [THR_W-1:0] KEEP_RESET  = 4'd4;
    localparam logic [THR_W-1:0] BIRTH_RESET = 4'd5;

    typedef struct packed {
        logic [THR_W-1:0] keep_threshold;
        logic [THR_W-1:0] birth_threshold;
        logic             avoid_big_spaces;
    } t_cfg;

    // One column as seen by its neighbours.
    typedef struct packed {
        logic older;
        logic newer;
        logic cur;
    } t_col;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic              done;
    } t_out_item;

    function automatic logic rule_bit(input logic mid, input logic [CNT_W-1:0] cnt,
                                      input t_cfg cfg);
        logic wall;
        if (mid) begin
            wall = (cnt >= cfg.keep_threshold)
                 || ((cnt == '0) && cfg.avoid_big_spaces);
        end else begin
            wall = (cnt >= cfg.birth_threshold);
        end
        return wall;
    endfunction

endpackage

[hw/rtl/cave_cell.sv]
// One column cell: holds the two buffered line bits and computes the column's results.
module cave_cell
    import cave_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  logic i_last,
    input  logic i_cur,
    input  t_cfg i_cfg,
    input  t_col i_left,
    input  t_col i_right,
    output t_col o_col,
    output logic o_mid_res,
    output logic o_last_res
);

    logic r_older;
    logic r_newer;
    logic [CNT_W-1:0] w_cnt_mid;
    logic [CNT_W-1:0] w_cnt_last;

    assign o_col = '{older: r_older, newer: r_newer, cur: i_cur};

    // Pending line between the older line and the incoming one.
    assign w_cnt_mid = CNT_W'(i_left.older) + CNT_W'(r_older) + CNT_W'(i_right.older)
                     + CNT_W'(i_left.newer) + CNT_W'(i_right.newer)
                     + CNT_W'(i_left.cur) + CNT_W'(i_cur) + CNT_W'(i_right.cur);

    // Final line: walls below it count three.
    assign w_cnt_last = CNT_W'(i_left.newer) + CNT_W'(r_newer) + CNT_W'(i_right.newer)
                      + CNT_W'(i_left.cur) + CNT_W'(i_right.cur) + CNT_W'(3);

    assign o_mid_res  = rule_bit(r_newer, w_cnt_mid, i_cfg);
    assign o_last_res = rule_bit(i_cur, w_cnt_last, i_cfg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older <= 1'b1;
            r_newer <= 1'b1;
        end else if (i_accept) begin
            if (i_last) begin
                r_older <= 1'b1;
                r_newer <= 1'b1;
            end else begin
                r_older <= r_newer;
                r_newer <= i_cur;
            end
        end
    end

endmodule

[hw/rtl/cave_out_queue.sv]
// Three-entry output queue that takes up to two result lines per cycle.
module cave_out_queue
    import cave_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_out_item i_item0,
    input  t_out_item i_item1,
    input  logic      i_pop,
    output t_out_item o_head,
    output logic      o_valid,
    output logic      o_full
);

    t_out_item r_q [3];
    t_out_item n_q [3];
    t_out_item w_sh [3];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [1:0] w_base;

    assign o_head  = r_q[0];
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt > 2'd1);

    assign w_base = r_cnt - 2'(i_pop);

    always_comb begin
        w_sh[0] = i_pop ? r_q[1] : r_q[0];
        w_sh[1] = i_pop ? r_q[2] : r_q[1];
        w_sh[2] = r_q[2];
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < w_base) begin
                n_q[k] = w_sh[k];
            end else if (2'(k) == w_base) begin
                n_q[k] = i_item0;
            end else begin
                n_q[k] = i_item1;
            end
        end
        n_cnt = w_base + i_push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_q[k] <= n_q[k];
        end
    end

endmodule

[hw/rtl/cave_automaton_row_step.sv]
// Top level of the cave automaton row step: cell row, configuration and output queue.
// Takes one grid line per cycle while o_stall is low and returns each line's next
// generation one line late, from a row of LINE_LENGTH column cells that each hold their
// bits of the two buffered lines and see their neighbours' bits; cells outside the grid
// read as walls. A result is in the output queue the cycle after the line that
// completes it. The final line of a grid of two or more lines yields two results, the
// last marked grid_done, and the output queue (three entries) then holds the input back
// when results drain one per cycle. Bits at and above LINE_LENGTH are ignored on input
// and zero on output. Configuration is taken at once.
module cave_automaton_row_step
    import cave_pkg::*;
#(
    parameter int LINE_LENGTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [LINE_W-1:0]     i_line_cells,
    input  logic                  i_grid_last_line,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [LINE_W-1:0]     o_new_line_cells,
    output logic                  o_grid_done
);

    t_cfg r_cfg;
    logic r_held;
    logic n_held;
    logic w_accept;
    logic w_full;
    logic w_pop;
    logic [1:0] w_push_n;
    logic [LINE_W-1:0] w_mid_res;
    logic [LINE_W-1:0] w_last_res;
    t_col w_col [LINE_LENGTH+2];
    t_out_item w_item0;
    t_out_item w_item1;
    t_out_item w_head;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;
    assign w_pop    = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{keep_threshold: KEEP_RESET, birth_threshold: BIRTH_RESET,
                       avoid_big_spaces: 1'b0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEEP_THRESHOLD:  r_cfg.keep_threshold   <= i_cfg_data;
                CFG_BIRTH_THRESHOLD: r_cfg.birth_threshold  <= i_cfg_data;
                CFG_AVOID_BIG:       r_cfg.avoid_big_spaces <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_col[0]             = '{older: 1'b1, newer: 1'b1, cur: 1'b1};
    assign w_col[LINE_LENGTH+1] = '{older: 1'b1, newer: 1'b1, cur: 1'b1};

    for (genvar j = 0; j < LINE_W; j++) begin : g_col
        if (j < LINE_LENGTH) begin : g_cell
            cave_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_accept   (w_accept),
                .i_last     (i_grid_last_line),
                .i_cur      (i_line_cells[j]),
                .i_cfg      (r_cfg),
                .i_left     (w_col[j]),
                .i_right    (w_col[j+2]),
                .o_col      (w_col[j+1]),
                .o_mid_res  (w_mid_res[j]),
                .o_last_res (w_last_res[j])
            );
        end else begin : g_pad
            assign w_mid_res[j]  = 1'b0;
            assign w_last_res[j] = 1'b0;
        end
    end

    // Hold one pending line until the line below it arrives.
    always_comb begin
        n_held = r_held;
        if (w_accept) begin
            n_held = !i_grid_last_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else begin
            r_held <= n_held;
        end
    end

    assign w_push_n = w_accept ? (2'(r_held) + 2'(i_grid_last_line)) : 2'd0;
    assign w_item0  = r_held ? t_out_item'{line: w_mid_res, done: 1'b0}
                             : t_out_item'{line: w_last_res, done: 1'b1};
    assign w_item1  = '{line: w_last_res, done: 1'b1};

    cave_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_item0  (w_item0),
        .i_item1  (w_item1),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_valid  (o_valid),
        .o_full   (w_full)
    );

    assign o_new_line_cells = w_head.line;
    assign o_grid_done      = w_head.done;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the cave automaton row step: directed lines, then random grids.
`timescale 1ns / 100ps

module tb_top;
    import cave_pkg::*;

    localparam int LINE_LEN        = 64;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int NUM_PHASES      = 8;
    localparam int PHASE_LINES     = 66;
    localparam int HOLD_PHASE      = 2;
    localparam int PAUSE_PHASE     = 4;
    localparam int DIRECTED_LEN    = 22;

    localparam logic [LINE_W-1:0] ALL_WALLS  = '1;
    localparam logic [LINE_W-1:0] EDGE_WALLS = 64'h8000_0000_0000_0001;

    typedef struct packed {
        logic [LINE_W-1:0] cells;
        logic              last;
        logic              known;
        logic [LINE_W-1:0] res_a;
        logic [LINE_W-1:0] res_b;
    } t_directed_row;

    typedef struct packed {
        logic [THR_W-1:0] keep;
        logic [THR_W-1:0] birth;
        logic             avoid;
    } t_setting;

    localparam t_directed_row DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{ALL_WALLS,             1'b1, 1'b1, ALL_WALLS,  '0},
        '{64'h0,                 1'b1, 1'b1, ALL_WALLS,  '0},
        '{64'h5555_5555_5555_5555, 1'b1, 1'b1, ALL_WALLS, '0},
        '{64'h0,                 1'b0, 1'b0, '0,         '0},
        '{64'h0,                 1'b0, 1'b1, EDGE_WALLS, '0},
        '{64'h0,                 1'b1, 1'b1, '0,         EDGE_WALLS},
        '{ALL_WALLS,             1'b0, 1'b0, '0,         '0},
        '{64'h0,                 1'b0, 1'b0, '0,         '0},
        '{ALL_WALLS,             1'b1, 1'b0, '0,         '0},
        '{64'h5555_5555_5555_5555, 1'b0, 1'b0, '0,       '0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0,       '0},
        '{64'h5555_5555_5555_5555, 1'b1, 1'b0, '0,       '0},
        '{64'h0000_0001_0000_0000, 1'b0, 1'b0, '0,       '0},
        '{EDGE_WALLS,            1'b0, 1'b0, '0,         '0},
        '{64'h1,                 1'b1, 1'b0, '0,         '0},
        '{64'hDEAD_BEEF_0123_4567, 1'b0, 1'b0, '0,       '0},
        '{64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, '0,       '0},
        '{64'hF0F0_0F0F_3C3C_C3C3, 1'b1, 1'b1, ALL_WALLS, '0},
        '{64'h0000_FFFF_0000_FFFF, 1'b0, 1'b0, '0,       '0},
        '{64'h00FF_00FF_00FF_00FF, 1'b0, 1'b0, '0,       '0},
        '{64'h0F0F_0F0F_0F0F_0F0F, 1'b0, 1'b0, '0,       '0},
        '{64'h3333_3333_3333_3333, 1'b1, 1'b0, '0,       '0}
    };

    localparam t_setting PHASE_SETTINGS [6] = '{
        '{4'd4,  4'd5,  1'b1},
        '{4'd0,  4'd9,  1'b0},
        '{4'd9,  4'd0,  1'b1},
        '{4'd15, 4'd15, 1'b0},
        '{4'd3,  4'd4,  1'b0},
        '{4'd9,  4'd9,  1'b1}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [LINE_W-1:0]     i_line_cells;
    logic                  i_grid_last_line;
    logic                  o_valid;
    logic                  i_stall;
    logic [LINE_W-1:0]     o_new_line_cells;
    logic                  o_grid_done;

    logic [THR_W-1:0]  keep_thr;
    logic [THR_W-1:0]  birth_thr;
    logic              avoid_big;
    logic [LINE_W-1:0] grid_above;
    logic [LINE_W-1:0] grid_pending;
    logic [1:0]        grid_held;
    t_out_item         step_out [2];
    t_out_item         evolved_q [$];

    bit tx_idle_en;
    bit rx_idle_en;
    bit hold_off_req;
    int cycle_count;
    int mismatches;
    int lines_sent;
    int grids_sent;
    int results_checked;
    int settings_used;

    cave_automaton_row_step #(
        .LINE_LENGTH(LINE_LEN)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_line_cells     (i_line_cells),
        .i_grid_last_line (i_grid_last_line),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_new_line_cells (o_new_line_cells),
        .o_grid_done      (o_grid_done)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic wall_at(input logic [LINE_W-1:0] line, input int k);
        if (k < 0 || k >= LINE_LEN) begin
            return 1'b1;
        end
        return line[k];
    endfunction

    function automatic logic [LINE_W-1:0] evolve_line(input logic [LINE_W-1:0] above,
                                                      input logic [LINE_W-1:0] mid,
                                                      input logic [LINE_W-1:0] below);
        logic [LINE_W-1:0] res;
        int                cnt;
        logic              wall;
        res = '0;
        for (int j = 0; j < LINE_LEN; j++) begin
            cnt = int'(wall_at(mid, j - 1)) + int'(wall_at(mid, j + 1));
            for (int dj = -1; dj <= 1; dj++) begin
                cnt += int'(wall_at(above, j + dj)) + int'(wall_at(below, j + dj));
            end
            if (mid[j]) begin
                wall = (cnt >= int'(keep_thr)) || (cnt == 0 && avoid_big);
            end else begin
                wall = (cnt >= int'(birth_thr));
            end
            res[j] = wall;
        end
        return res;
    endfunction

    // Advance the three-line window by one line; results land in step_out.
    function automatic int advance_grid(input logic [LINE_W-1:0] cur, input logic last);
        int n;
        n = 0;
        if (grid_held != 2'd0) begin
            step_out[0].line = evolve_line(grid_above, grid_pending, cur);
            step_out[0].done = 1'b0;
            n = 1;
        end
        if (last) begin
            step_out[n].line = evolve_line((grid_held != 2'd0) ? grid_pending : ALL_WALLS,
                                           cur, ALL_WALLS);
            step_out[n].done = 1'b1;
            n++;
            grid_above   = ALL_WALLS;
            grid_pending = ALL_WALLS;
            grid_held    = 2'd0;
        end else begin
            grid_above   = (grid_held != 2'd0) ? grid_pending : ALL_WALLS;
            grid_pending = cur;
            grid_held    = (grid_held != 2'd0) ? 2'd2 : 2'd1;
        end
        return n;
    endfunction

    function automatic logic [LINE_W-1:0] random_cells();
        logic [LINE_W-1:0] a;
        logic [LINE_W-1:0] b;
        logic [LINE_W-1:0] c;
        logic [LINE_W-1:0] d;
        logic [LINE_W-1:0] lone;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        d = {$urandom, $urandom};
        lone = 64'd1 << $urandom_range(0, LINE_LEN - 1);
        case ($urandom_range(0, 11)) inside
            [0:3]:   return a;
            [4:5]:   return a & b & c & d;
            [6:7]:   return a | b | c;
            8:       return a & b;
            9:       return lone;
            10:      return ~lone;
            default: return ($urandom_range(0, 1) == 1) ? ALL_WALLS : '0;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (!tx_idle_en) begin
            return 0;
        end
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return 0;
        end else if (r < 9) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_grid_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 1;
        end else if (r < 8) begin
            return $urandom_range(2, 6);
        end
        return $urandom_range(7, 20);
    endfunction

    function automatic void report_mismatch(input string what, input logic [LINE_W-1:0] want,
                                            input logic [LINE_W-1:0] got);
        if (mismatches < 10) begin
            $display("[%0t] %s mismatch: expected %h, got %h", $realtime, what, want, got);
        end
        mismatches++;
    endfunction

    task automatic send_line(input logic [LINE_W-1:0] cells, input logic last,
                             input logic known, input logic [LINE_W-1:0] res_a,
                             input logic [LINE_W-1:0] res_b);
        int        gap;
        int        n;
        t_out_item item;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_line_cells     <= cells;
        i_grid_last_line <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        lines_sent++;
        if (last) begin
            grids_sent++;
        end
        n = advance_grid(cells, last);
        for (int k = 0; k < n; k++) begin
            item = step_out[k];
            if (known) begin
                item.line = (k == 0) ? res_a : res_b;
            end
            evolved_q.push_back(item);
        end
    endtask

    task automatic wait_drained(input int settle);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (evolved_q.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_setting s);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_KEEP_THRESHOLD;
        i_cfg_data <= s.keep;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BIRTH_THRESHOLD;
        i_cfg_data <= s.birth;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_AVOID_BIG;
        i_cfg_data <= CFG_DATA_W'(s.avoid);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        keep_thr  = s.keep;
        birth_thr = s.birth;
        avoid_big = s.avoid;
        settings_used++;
    endtask

    // Receiver: random stall runs, plus one long hold-off on request.
    initial begin : rx_side
        int run;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_off_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
                i_stall <= 1'b1;
                repeat (run) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (evolved_q.size() == 0) begin
                report_mismatch("unexpected item", '0, o_new_line_cells);
            end else begin
                want = evolved_q.pop_front();
                results_checked++;
                if (o_new_line_cells !== want.line) begin
                    report_mismatch("new_line_cells", want.line, o_new_line_cells);
                end
                if (o_grid_done !== want.done) begin
                    report_mismatch("grid_done", LINE_W'(want.done), LINE_W'(o_grid_done));
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d items still expected", cycle_count,
                 evolved_q.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int       phase_lines;
        int       grid_len;
        bit       first;
        t_setting s;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_KEEP_THRESHOLD;
        i_cfg_data       = '0;
        i_valid          = 1'b0;
        i_line_cells     = '0;
        i_grid_last_line = 1'b0;
        i_stall          = 1'b0;
        keep_thr         = KEEP_RESET;
        birth_thr        = BIRTH_RESET;
        avoid_big        = 1'b0;
        grid_above       = ALL_WALLS;
        grid_pending     = ALL_WALLS;
        grid_held        = 2'd0;
        tx_idle_en       = 1'b1;
        rx_idle_en       = 1'b1;
        hold_off_req     = 1'b0;
        mismatches       = 0;
        lines_sent       = 0;
        grids_sent       = 0;
        results_checked  = 0;
        settings_used    = 1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[i]) begin
            send_line(DIRECTED_ROWS[i].cells, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].known,
                      DIRECTED_ROWS[i].res_a, DIRECTED_ROWS[i].res_b);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained(4);
            if (p < 6) begin
                s = PHASE_SETTINGS[p];
            end else begin
                s.keep  = THR_W'($urandom_range(0, 9));
                s.birth = THR_W'($urandom_range(0, 9));
                s.avoid = 1'($urandom_range(0, 1));
            end
            apply_settings(s);
            phase_lines = 0;
            first = 1'b1;
            while (phase_lines < PHASE_LINES) begin
                tx_idle_en = ($urandom_range(0, 4) != 0);
                rx_idle_en = ($urandom_range(0, 4) != 0);
                grid_len = pick_grid_len();
                if (first && p == HOLD_PHASE) begin
                    grid_len     = 24;
                    tx_idle_en   = 1'b0;
                    hold_off_req = 1'b1;
                end
                if (first && p == PAUSE_PHASE) begin
                    grid_len = 6;
                end
                for (int r = 0; r < grid_len; r++) begin
                    send_line(random_cells(), r == grid_len - 1, 1'b0, '0, '0);
                    if (first && p == PAUSE_PHASE && r == 2) begin
                        wait_drained(0);
                    end
                end
                phase_lines += grid_len;
                first = 1'b0;
            end
        end

        wait_drained(20);
        $display("Sent %0d lines in %0d grids under %0d register settings;", lines_sent,
                 grids_sent, settings_used);
        $display("checked %0d result lines, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/cave_pkg.sv
hw/rtl/cave_cell.sv
hw/rtl/cave_out_queue.sv
hw/rtl/cave_automaton_row_step.sv
dv/tb_top.sv
